// ===== design/tcg_pkg.sv =====
`default_nettype none
package tcg_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int ANGLE_WIDTH  = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int FULL_TURN     = 23040;
  localparam int QUARTER_TURN  = 5760;
  localparam int HALF_TURN     = 11520;
  localparam int THREE_QUARTER = 17280;

  localparam int LEN_W   = 16;
  localparam int COLOR_W = 24;
  localparam int XY_W    = 33;
  localparam int Z_W     = 27;
  localparam int PROD_W  = LEN_W + XY_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int STEP_W  = $clog2(CORDIC_STEPS);
  localparam int WANG_W  = ANGLE_WIDTH + 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic signed [XY_W-1:0]   CORDIC_GAIN = XY_W'(652032874);
  localparam logic signed [WANG_W-1:0] FULL_TURN_W = WANG_W'(FULL_TURN);
  localparam logic signed [Z_W-1:0]    HALF_Z      = Z_W'(HALF_TURN * 1024);
  localparam logic signed [Z_W-1:0]    FULL_Z      = Z_W'(FULL_TURN * 1024);
  localparam logic signed [ACC_W-1:0]  Q30_M1      = ACC_W'((64'sd1 <<< 30) - 1);
  localparam logic signed [ACC_W-1:0]  COORD_MAX   =
    ACC_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0]  COORD_MIN   = -COORD_MAX - 1;

  typedef enum logic [2:0] {
    OP_FORWARD   = 3'd0,
    OP_ROTATE    = 3'd1,
    OP_PEN_UP    = 3'd2,
    OP_PEN_DOWN  = 3'd3,
    OP_SET_COLOR = 3'd4,
    OP_CIRCLE    = 3'd5,
    OP_ARC       = 3'd6,
    OP_SET_POSE  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    PRIM_LINE   = 2'd0,
    PRIM_CIRCLE = 2'd1,
    PRIM_ARC    = 2'd2
  } prim_t;

  typedef struct packed {
    op_t                            op;
    logic                           uses_cordic;
    logic signed [LEN_W-1:0]        length;
    logic signed [ANGLE_WIDTH-1:0]  turn;
    logic [COLOR_W-1:0]             color;
    logic signed [COORD_WIDTH-1:0]  pose_x;
    logic signed [COORD_WIDTH-1:0]  pose_y;
    logic                           pose_pen;
    logic [ANGLE_WIDTH-1:0]         pose_heading;
  } cmd_entry_t;

  function automatic logic [ANGLE_WIDTH-1:0] wrap_angle(input logic signed [WANG_W-1:0] a);
    logic signed [WANG_W-1:0] v;
    v = a;
    if (v < 0) v = v + FULL_TURN_W;
    if (v < 0) v = v + FULL_TURN_W;
    if (v >= FULL_TURN_W) v = v - FULL_TURN_W;
    if (v >= FULL_TURN_W) v = v - FULL_TURN_W;
    return v[ANGLE_WIDTH-1:0];
  endfunction

  function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] r;
    case (int'(i))
      0: r = Z_W'(2949120);
      1: r = Z_W'(1740967);
      2: r = Z_W'(919879);
      3: r = Z_W'(466945);
      4: r = Z_W'(234379);
      5: r = Z_W'(117304);
      6: r = Z_W'(58665);
      7: r = Z_W'(29335);
      8: r = Z_W'(14668);
      9: r = Z_W'(7334);
      10: r = Z_W'(3667);
      11: r = Z_W'(1833);
      12: r = Z_W'(917);
      13: r = Z_W'(458);
      14: r = Z_W'(229);
      15: r = Z_W'(115);
      16: r = Z_W'(57);
      17: r = Z_W'(29);
      18: r = Z_W'(14);
      19: r = Z_W'(7);
      20: r = Z_W'(4);
      21: r = Z_W'(2);
      22: r = Z_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // truncate a q30 sum toward zero, then clamp to the coordinate range
  function automatic logic signed [COORD_WIDTH-1:0] to_coord(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v < 0) ? v + Q30_M1 : v;
    t = t >>> 30;
    if (t > COORD_MAX) t = COORD_MAX;
    if (t < COORD_MIN) t = COORD_MIN;
    return t[COORD_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/tcg_cmd_if.sv =====
`default_nettype none
interface tcg_cmd_if;
  import tcg_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [2:0]                    kind;
  logic signed [LEN_W-1:0]       length;
  logic signed [ANGLE_WIDTH-1:0] turn_angle;
  logic [COLOR_W-1:0]            color;
  logic signed [COORD_WIDTH-1:0] pose_x;
  logic signed [COORD_WIDTH-1:0] pose_y;
  logic                          pose_pen_down;

  modport source (output valid, kind, length, turn_angle, color, pose_x, pose_y,
                  pose_pen_down, input ready);
  modport sink (input valid, kind, length, turn_angle, color, pose_x, pose_y,
                pose_pen_down, output ready);
endinterface
`default_nettype wire

// ===== design/tcg_prim_if.sv =====
`default_nettype none
interface tcg_prim_if;
  import tcg_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [1:0]                    primitive_res;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;
  logic signed [LEN_W-1:0]       radius_out;
  logic [ANGLE_WIDTH-1:0]        start_degrees;
  logic signed [ANGLE_WIDTH:0]   end_degrees;
  logic [COLOR_W-1:0]            draw_color;

  modport source (output valid, primitive_res, first_x, first_y, second_x, second_y,
                  radius_out, start_degrees, end_degrees, draw_color, input ready);
  modport sink (input valid, primitive_res, first_x, first_y, second_x, second_y,
                radius_out, start_degrees, end_degrees, draw_color, output ready);
endinterface
`default_nettype wire

// ===== design/tcg_front.sv =====
`default_nettype none
module tcg_front (
  tcg_cmd_if.sink             cmd,
  input  wire logic           full,
  output logic                push,
  output tcg_pkg::cmd_entry_t entry
);
  import tcg_pkg::*;

  assign cmd.ready = !full;
  assign push      = cmd.valid && !full;

  always_comb begin
    entry.op           = op_t'(cmd.kind);
    entry.length       = cmd.length;
    entry.turn         = cmd.turn_angle;
    entry.color        = cmd.color;
    entry.pose_x       = cmd.pose_x;
    entry.pose_y       = cmd.pose_y;
    entry.pose_pen     = cmd.pose_pen_down;
    entry.pose_heading = wrap_angle(WANG_W'(cmd.turn_angle));
    unique case (op_t'(cmd.kind)) inside
      OP_FORWARD, OP_CIRCLE, OP_ARC: entry.uses_cordic = 1'b1;
      default:                       entry.uses_cordic = 1'b0;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/tcg_queue.sv =====
`default_nettype none
module tcg_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire tcg_pkg::cmd_entry_t push_data,
  output logic                     full,
  input  wire logic                pop,
  output tcg_pkg::cmd_entry_t      pop_data,
  output logic                     valid
);
  import tcg_pkg::*;

  cmd_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full     = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== design/tcg_back.sv =====
`default_nettype none
module tcg_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire tcg_pkg::cmd_entry_t q_data,
  output logic                     q_pop,
  tcg_prim_if.source               prim
);
  import tcg_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CORDIC = 7'b0000010,
    ST_MUL_S  = 7'b0000100,
    ST_MUL_C  = 7'b0001000,
    ST_ADD_C  = 7'b0010000,
    ST_CENTRE = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t state;

  logic signed [COORD_WIDTH-1:0] pos_x, pos_y;
  logic [ANGLE_WIDTH-1:0]        heading;
  logic                          pen_down;
  logic [COLOR_W-1:0]            ink_color;

  op_t                           op;
  logic signed [LEN_W-1:0]       len;
  logic signed [ANGLE_WIDTH-1:0] turn;
  logic [ANGLE_WIDTH-1:0]        nh;
  logic                          pass;

  logic signed [XY_W-1:0]        cx, cy;
  logic signed [Z_W-1:0]         cz;
  logic                          neg;
  logic [STEP_W-1:0]             step;

  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc_x, acc_y;
  logic signed [COORD_WIDTH-1:0] cen_x, cen_y;

  logic                          out_valid;
  logic [1:0]                    out_prim;
  logic signed [COORD_WIDTH-1:0] out_fx, out_fy, out_sx, out_sy;
  logic signed [LEN_W-1:0]       out_rad;
  logic [ANGLE_WIDTH-1:0]        out_start;
  logic signed [ANGLE_WIDTH:0]   out_end;
  logic [COLOR_W-1:0]            out_color;

  logic [ANGLE_WIDTH-1:0]        ang_start;
  logic signed [Z_W-1:0]         z_start;
  logic                          neg_start;
  logic signed [XY_W-1:0]        sin_v, cos_v, mul_op;
  logic signed [ACC_W-1:0]       prod_ext;
  logic [ANGLE_WIDTH-1:0]        nh_calc;
  logic signed [COORD_WIDTH-1:0] new_x, new_y;
  logic [ANGLE_WIDTH-1:0]        arc_start;
  logic signed [WANG_W-1:0]      arc_end_w;
  logic signed [ANGLE_WIDTH:0]   arc_end;
  logic                          emit;
  logic                          out_free;

  assign prim.valid         = out_valid;
  assign prim.primitive_res = out_prim;
  assign prim.first_x       = out_fx;
  assign prim.first_y       = out_fy;
  assign prim.second_x      = out_sx;
  assign prim.second_y      = out_sy;
  assign prim.radius_out    = out_rad;
  assign prim.start_degrees = out_start;
  assign prim.end_degrees   = out_end;
  assign prim.draw_color    = out_color;

  assign q_pop = (state == ST_IDLE) && q_valid;

  // fold the angle into [-90, 90] degrees before rotating
  always_comb begin
    ang_start = (state == ST_IDLE) ? heading : nh;
    z_start   = Z_W'({ang_start, 10'b0});
    neg_start = 1'b0;
    if (ang_start > ANGLE_WIDTH'(QUARTER_TURN) && ang_start <= ANGLE_WIDTH'(THREE_QUARTER)) begin
      z_start   = z_start - HALF_Z;
      neg_start = 1'b1;
    end else if (ang_start > ANGLE_WIDTH'(THREE_QUARTER)) begin
      z_start = z_start - FULL_Z;
    end
  end

  assign sin_v    = neg ? -cy : cy;
  assign cos_v    = neg ? -cx : cx;
  assign mul_op   = (state == ST_MUL_S) ? sin_v : cos_v;
  assign prod_ext = ACC_W'(prod);

  assign nh_calc  = wrap_angle($signed({2'b00, heading}) + WANG_W'(q_data.turn));
  assign new_x    = to_coord(acc_x);
  assign new_y    = to_coord(acc_y);

  assign arc_start = heading + ANGLE_WIDTH'(THREE_QUARTER);
  assign arc_end_w = $signed({2'b00, arc_start}) + WANG_W'(turn);
  assign arc_end   = (arc_end_w > WANG_W'(65535)) ? (ANGLE_WIDTH + 1)'(65535)
                                                  : arc_end_w[ANGLE_WIDTH:0];

  assign emit     = pen_down;
  assign out_free = !out_valid || prim.ready;

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_valid && q_data.uses_cordic) begin
          op    <= q_data.op;
          len   <= q_data.length;
          turn  <= q_data.turn;
          nh    <= nh_calc;
          pass  <= 1'b0;
          acc_x <= ACC_W'(pos_x) <<< 30;
          acc_y <= ACC_W'(pos_y) <<< 30;
          cx    <= CORDIC_GAIN;
          cy    <= '0;
          cz    <= z_start;
          neg   <= neg_start;
          step  <= '0;
        end
      end
      ST_CORDIC: begin
        if (cz >= 0) begin
          cx <= cx - (cy >>> step);
          cy <= cy + (cx >>> step);
          cz <= cz - atan_step(step);
        end else begin
          cx <= cx + (cy >>> step);
          cy <= cy - (cx >>> step);
          cz <= cz + atan_step(step);
        end
        step <= step + 1'b1;
      end
      ST_MUL_S: prod <= PROD_W'(len) * PROD_W'(mul_op);
      ST_MUL_C: begin
        prod <= PROD_W'(len) * PROD_W'(mul_op);
        if (op == OP_FORWARD) acc_y <= acc_y + prod_ext;
        else if (!pass)       acc_x <= acc_x - prod_ext;
        else                  acc_x <= acc_x + prod_ext;
      end
      ST_ADD_C: begin
        if (op == OP_FORWARD) acc_x <= acc_x + prod_ext;
        else if (!pass)       acc_y <= acc_y + prod_ext;
        else                  acc_y <= acc_y - prod_ext;
      end
      ST_CENTRE: begin
        cen_x <= new_x;
        cen_y <= new_y;
        pass  <= 1'b1;
        cx    <= CORDIC_GAIN;
        cy    <= '0;
        cz    <= z_start;
        neg   <= neg_start;
        step  <= '0;
      end
      ST_FINISH: begin
        if (emit && out_free) begin
          out_color <= ink_color;
          out_start <= '0;
          out_end   <= '0;
          if (op == OP_FORWARD) begin
            out_prim <= PRIM_LINE;
            out_fx   <= pos_x;
            out_fy   <= pos_y;
            out_sx   <= new_x;
            out_sy   <= new_y;
            out_rad  <= '0;
          end else begin
            out_prim <= (op == OP_ARC) ? PRIM_ARC : PRIM_CIRCLE;
            out_fx   <= cen_x;
            out_fy   <= cen_y;
            out_sx   <= '0;
            out_sy   <= '0;
            out_rad  <= len;
            if (op == OP_ARC) begin
              out_start <= arc_start;
              out_end   <= arc_end;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos_x     <= '0;
      pos_y     <= '0;
      heading   <= '0;
      pen_down  <= 1'b0;
      ink_color <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && prim.ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            unique case (q_data.op)
              OP_ROTATE:    heading <= nh_calc;
              OP_PEN_UP:    pen_down <= 1'b0;
              OP_PEN_DOWN:  pen_down <= 1'b1;
              OP_SET_COLOR: ink_color <= q_data.color;
              OP_SET_POSE: begin
                pos_x     <= q_data.pose_x;
                pos_y     <= q_data.pose_y;
                heading   <= q_data.pose_heading;
                ink_color <= q_data.color;
                pen_down  <= q_data.pose_pen;
              end
              default: state <= ST_CORDIC;
            endcase
          end
        end
        ST_CORDIC: if (step == STEP_W'(CORDIC_STEPS - 1)) state <= ST_MUL_S;
        ST_MUL_S:  state <= ST_MUL_C;
        ST_MUL_C:  state <= ST_ADD_C;
        ST_ADD_C:  state <= (op == OP_FORWARD || pass) ? ST_FINISH : ST_CENTRE;
        ST_CENTRE: state <= (op == OP_ARC) ? ST_CORDIC : ST_FINISH;
        ST_FINISH: begin
          if (!emit || out_free) begin
            if (emit) out_valid <= 1'b1;
            if (op != OP_CIRCLE) begin
              pos_x <= new_x;
              pos_y <= new_y;
            end
            if (op == OP_ARC) heading <= nh;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/turtle_graphics_command_engine.sv =====
`default_nettype none
// turtle graphics command engine
// cmd channel (valid/ready) takes one turtle command per transfer: forward,
// rotate, pen up/down, set color, circle, arc or set pose. prim channel
// (valid/ready) gives one line, circle or arc per drawing command while the
// pen is down; other commands and pen-up moves give nothing.
// commands pass a decoder into a two-entry queue, so cmd stays ready while
// the executer works. the executer runs one command at a time.
// state-only commands are done in the executer's idle state; forward and
// circle make one 16-step cordic run and arc makes two, all on one shared
// iterative rotator plus one 16x33 multiplier used twice per run.
// sustained throughput for drawing commands is set by that rotator.
// the result sits in an output register; while prim is stalled with a result
// waiting, the executer holds the next primitive and the queue fills, then
// cmd ready drops.
// synchronous reset: turtle at the origin, heading 0, pen up, color black,
// queue and output register empty.
module turtle_graphics_command_engine (
  input  wire logic  clk,
  input  wire logic  rst,
  tcg_cmd_if.sink    cmd,
  tcg_prim_if.source prim
);
  import tcg_pkg::*;

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  cmd_entry_t push_entry;
  cmd_entry_t head_entry;

  tcg_front u_front (
    .cmd   (cmd),
    .full  (q_full),
    .push  (q_push),
    .entry (push_entry)
  );

  tcg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (head_entry),
    .valid     (q_valid)
  );

  tcg_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (head_entry),
    .q_pop   (q_pop),
    .prim    (prim)
  );
endmodule
`default_nettype wire

// ===== tb/sv/turtle_graphics_command_engine_checker.sv =====
module turtle_graphics_command_engine_checker
  import tcg_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  tcg_cmd_if.sink         cmd_mon,
  tcg_prim_if.sink        prim_mon,
  output int              fail_count,
  output int              pending_prims,
  output int              prims_seen
);

  typedef struct packed {
    logic [1:0]                    prim;
    logic signed [COORD_WIDTH-1:0] fx;
    logic signed [COORD_WIDTH-1:0] fy;
    logic signed [COORD_WIDTH-1:0] sx;
    logic signed [COORD_WIDTH-1:0] sy;
    logic signed [LEN_W-1:0]       rad;
    logic [ANGLE_WIDTH-1:0]        st;
    logic signed [ANGLE_WIDTH:0]   en;
    logic [COLOR_W-1:0]            col;
  } prim_exp_t;

  prim_exp_t drawn_q[$];

  longint turtle_x, turtle_y, turtle_head;
  bit     turtle_pen;
  logic [COLOR_W-1:0] turtle_color;

  localparam longint ATAN_TBL [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58665, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint q30_to_coord(longint v);
    longint t;
    t = (v >= 0) ? (v >>> 30) : -((-v) >>> 30);
    return clamp(t, COORD_WIDTH);
  endfunction

  function automatic longint wrap_turn(longint a);
    return ((a % FULL_TURN) + FULL_TURN) % FULL_TURN;
  endfunction

  task automatic rotate_vec(input longint ang, output longint sn, output longint cs);
    longint z, x, y, nx;
    bit neg;
    z = ang * 1024; x = 652032874; y = 0; neg = 0;
    if (ang > QUARTER_TURN && ang <= THREE_QUARTER) begin
      z -= longint'(HALF_TURN) * 1024;
      neg = 1;
    end else if (ang > THREE_QUARTER) begin
      z -= longint'(FULL_TURN) * 1024;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= ATAN_TBL[i];
      end else begin
        nx = x + shr_floor(y, i); y = y - shr_floor(x, i); z += ATAN_TBL[i];
      end
      x = nx;
    end
    sn = neg ? -y : y;
    cs = neg ? -x : x;
  endtask

  task automatic apply_command(input logic [2:0] kind, input logic signed [15:0] len16,
                               input logic signed [ANGLE_WIDTH-1:0] turn16,
                               input logic [COLOR_W-1:0] col, input logic signed [15:0] px,
                               input logic signed [15:0] py, input logic pp);
    longint len, turn, s, c, s2, c2, nx, ny, nh, stv;
    prim_exp_t e;
    len = len16; turn = turn16;
    e = '0;
    e.col = turtle_color;
    case (op_t'(kind))
      OP_FORWARD: begin
        rotate_vec(turtle_head, s, c);
        nx = q30_to_coord(turtle_x * (longint'(1) <<< 30) + len * c);
        ny = q30_to_coord(turtle_y * (longint'(1) <<< 30) + len * s);
        if (turtle_pen) begin
          e.prim = PRIM_LINE;
          e.fx = COORD_WIDTH'(turtle_x); e.fy = COORD_WIDTH'(turtle_y);
          e.sx = COORD_WIDTH'(nx); e.sy = COORD_WIDTH'(ny);
          drawn_q.push_back(e);
        end
        turtle_x = nx; turtle_y = ny;
      end
      OP_ROTATE:    turtle_head = wrap_turn(turtle_head + turn);
      OP_PEN_UP:    turtle_pen = 0;
      OP_PEN_DOWN:  turtle_pen = 1;
      OP_SET_COLOR: turtle_color = col;
      OP_CIRCLE, OP_ARC: begin
        rotate_vec(turtle_head, s, c);
        if (turtle_pen) begin
          e.prim = (op_t'(kind) == OP_CIRCLE) ? PRIM_CIRCLE : PRIM_ARC;
          e.fx = COORD_WIDTH'(q30_to_coord(turtle_x * (longint'(1) <<< 30) - len * s));
          e.fy = COORD_WIDTH'(q30_to_coord(turtle_y * (longint'(1) <<< 30) + len * c));
          e.rad = len16;
          if (op_t'(kind) == OP_ARC) begin
            stv = turtle_head + THREE_QUARTER;
            e.st = ANGLE_WIDTH'(stv);
            e.en = (ANGLE_WIDTH + 1)'(clamp(stv + turn, ANGLE_WIDTH + 1));
          end
          drawn_q.push_back(e);
        end
        if (op_t'(kind) == OP_ARC) begin
          nh = wrap_turn(turtle_head + turn);
          rotate_vec(nh, s2, c2);
          nx = q30_to_coord(turtle_x * (longint'(1) <<< 30) - len * s + len * s2);
          ny = q30_to_coord(turtle_y * (longint'(1) <<< 30) + len * c - len * c2);
          turtle_x = nx; turtle_y = ny; turtle_head = nh;
        end
      end
      default: begin
        turtle_x = px; turtle_y = py;
        turtle_head = wrap_turn(turn);
        turtle_color = col;
        turtle_pen = pp;
      end
    endcase
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending_prims = drawn_q.size();

  initial begin
    fail_count = 0;
    prims_seen = 0;
  end

  always @(posedge clk) begin
    prim_exp_t e;
    if (rst) begin
      drawn_q.delete();
      turtle_x = 0; turtle_y = 0; turtle_head = 0; turtle_pen = 0; turtle_color = '0;
    end else begin
      // a result and a command in the same cycle: compare first, the new command is later
      if (prim_mon.valid && prim_mon.ready) begin
        prims_seen++;
        if (drawn_q.size() == 0) begin
          report("unexpected primitive", prim_mon.primitive_res, -1);
        end else begin
          e = drawn_q.pop_front();
          if (prim_mon.primitive_res !== e.prim) report("primitive", prim_mon.primitive_res, e.prim);
          if (prim_mon.first_x !== e.fx) report("first_x", prim_mon.first_x, e.fx);
          if (prim_mon.first_y !== e.fy) report("first_y", prim_mon.first_y, e.fy);
          if (prim_mon.second_x !== e.sx) report("second_x", prim_mon.second_x, e.sx);
          if (prim_mon.second_y !== e.sy) report("second_y", prim_mon.second_y, e.sy);
          if (prim_mon.radius_out !== e.rad) report("radius", prim_mon.radius_out, e.rad);
          if (prim_mon.start_degrees !== e.st) report("start", prim_mon.start_degrees, e.st);
          if (prim_mon.end_degrees !== e.en) report("end", prim_mon.end_degrees, e.en);
          if (prim_mon.draw_color !== e.col) report("color", prim_mon.draw_color, e.col);
        end
      end
      if (cmd_mon.valid && cmd_mon.ready)
        apply_command(cmd_mon.kind, cmd_mon.length, cmd_mon.turn_angle, cmd_mon.color,
                      cmd_mon.pose_x, cmd_mon.pose_y, cmd_mon.pose_pen_down);
    end
  end

endmodule

// ===== tb/sv/turtle_graphics_command_engine_tb.sv =====
module turtle_graphics_command_engine_tb;
  import tcg_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending_prims, prims_seen;
  int   cmds_sent = 0;

  tcg_cmd_if  cmd();
  tcg_prim_if prim();

  turtle_graphics_command_engine dut (.clk(clk), .rst(rst), .cmd(cmd), .prim(prim));

  turtle_graphics_command_engine_checker scoreboard (
    .clk(clk), .rst(rst), .cmd_mon(cmd), .prim_mon(prim),
    .fail_count(fail_count), .pending_prims(pending_prims), .prims_seen(prims_seen)
  );

  always #1 clk = ~clk;

  initial begin
    cmd.valid = 0; cmd.kind = '0; cmd.length = '0; cmd.turn_angle = '0; cmd.color = '0;
    cmd.pose_x = '0; cmd.pose_y = '0; cmd.pose_pen_down = 0;
    prim.ready = 0;
  end

  // receiver stall pattern: long open stretches, then bursts of random stalls
  initial begin
    int mode;
    @(negedge rst);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 120)) begin
        @(posedge clk);
        case (mode)
          0: prim.ready <= 1;
          1: prim.ready <= ($urandom_range(0, 3) != 0);
          2: prim.ready <= ($urandom_range(0, 3) == 0);
          default: prim.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // one transfer; valid stays high if the next call follows at once
  task automatic send_cmd(input op_t op, input logic signed [15:0] len,
                          input logic signed [15:0] ang, input logic [23:0] col,
                          input logic signed [15:0] px, input logic signed [15:0] py,
                          input logic pp);
    cmd.valid <= 1; cmd.kind <= op; cmd.length <= len; cmd.turn_angle <= ang;
    cmd.color <= col; cmd.pose_x <= px; cmd.pose_y <= py; cmd.pose_pen_down <= pp;
    do @(posedge clk); while (!cmd.ready);
    cmd_sent_hook();
  endtask

  function automatic void cmd_sent_hook();
    cmds_sent++;
  endfunction

  task automatic gap();
    cmd.valid <= 0;
    repeat ($urandom_range(1, 60)) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_len();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'sh7fff;
      2: return -16'sd32768;
      default: return $signed(16'($urandom_range(0, 400))) - 16'sd200;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_ang();
    case ($urandom_range(0, 4))
      0: return $signed(16'($urandom_range(0, 46080))) - 16'sd23040;
      1: return ($urandom_range(0, 1)) ? 16'sd23040 : -16'sd23040;
      2: return $signed(16'($urandom_range(0, 8)) * 16'sd2880) - 16'sd11520;
      default: return $signed(16'($urandom_range(0, 11520))) - 16'sd5760;
    endcase
  endfunction

  task automatic rand_cmd();
    op_t op;
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) op = OP_FORWARD;
    else if (r < 37) op = OP_ROTATE;
    else if (r < 42) op = OP_PEN_UP;
    else if (r < 52) op = OP_PEN_DOWN;
    else if (r < 58) op = OP_SET_COLOR;
    else if (r < 72) op = OP_CIRCLE;
    else if (r < 92) op = OP_ARC;
    else op = OP_SET_POSE;
    send_cmd(op, rand_len(), rand_ang(), 24'($urandom), 16'($urandom), 16'($urandom),
             1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: every command, extreme lengths and angles, saturation, wrap
    send_cmd(OP_FORWARD, 16'sd100, 0, 0, 0, 0, 0);
    send_cmd(OP_ARC, 16'sd50, 16'sd5760, 0, 0, 0, 0);
    send_cmd(OP_PEN_DOWN, 0, 0, 0, 0, 0, 0);
    send_cmd(OP_SET_COLOR, 0, 0, 24'hffffff, 0, 0, 0);
    send_cmd(OP_FORWARD, 16'sh7fff, 0, 0, 0, 0, 0);
    send_cmd(OP_FORWARD, 16'sh7fff, 0, 0, 0, 0, 0);
    send_cmd(OP_ROTATE, 16'sd23040, -16'sd23040, 0, 0, 0, 0);
    send_cmd(OP_ROTATE, 0, 16'sd23040, 0, 0, 0, 0);
    send_cmd(OP_ROTATE, 0, 16'sd5761, 0, 0, 0, 0);
    send_cmd(OP_FORWARD, -16'sd32768, 0, 0, 0, 0, 0);
    send_cmd(OP_CIRCLE, -16'sd32768, 0, 0, 0, 0, 0);
    send_cmd(OP_CIRCLE, 16'sh7fff, 0, 0, 0, 0, 0);
    send_cmd(OP_ARC, -16'sd77, 16'sd23040, 0, 0, 0, 0);
    send_cmd(OP_SET_POSE, 0, 16'sd23039, 24'h000000, 16'sh7fff, -16'sd32768, 1);
    send_cmd(OP_ARC, 16'sd300, 16'sd23040, 0, 0, 0, 0);
    send_cmd(OP_ARC, 16'sd300, -16'sd23040, 0, 0, 0, 0);
    send_cmd(OP_SET_POSE, 16'shffff, -16'sd23040, 24'hffffff, -16'sd32768, 16'sh7fff, 0);
    send_cmd(OP_CIRCLE, 16'sd10, 0, 0, 0, 0, 0);
    send_cmd(OP_FORWARD, 16'sd10, 0, 0, 0, 0, 0);
    send_cmd(OP_PEN_DOWN, 0, 0, 0, 0, 0, 0);
    send_cmd(OP_ROTATE, 0, 16'sd11520, 0, 0, 0, 0);
    send_cmd(OP_FORWARD, 16'sd5, 0, 0, 0, 0, 0);
    send_cmd(OP_SET_POSE, 16'sd0, 16'sd17280, 24'h5a5a5a, 0, 0, 1);
    send_cmd(OP_ARC, 16'sd1, 16'sd1, 0, 0, 0, 0);
    send_cmd(OP_PEN_UP, 0, 0, 0, 0, 0, 0);
    gap();
    // random: bursts of commands with gaps, recentred now and then
    while (cmds_sent < 825) begin
      repeat ($urandom_range(1, 25)) begin
        if ($urandom_range(0, 30) == 0)
          send_cmd(OP_SET_POSE, 0, rand_ang(), 24'($urandom),
                   $signed(16'($urandom_range(0, 1000))) - 16'sd500,
                   $signed(16'($urandom_range(0, 1000))) - 16'sd500, 1);
        else
          rand_cmd();
      end
      if ($urandom_range(0, 2) != 0) gap();
    end
    cmd.valid <= 0;
    wait (pending_prims == 0);
    repeat (100) @(posedge clk);
    $display("sent %0d commands covering all kinds, checked %0d primitives",
             cmds_sent, prims_seen);
    if (fail_count == 0 && pending_prims == 0)
      $display("turtle_graphics_command_engine verification clean");
    else
      $display("turtle_graphics_command_engine verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout waiting for the block");
    $display("turtle_graphics_command_engine verification failed");
    $finish;
  end

endmodule
